// ===== rtl/core/frustum_cull_test_defines.svh =====
// Assertion macros used by the frustum culling RTL.
`ifndef FRUSTUM_CULL_TEST_DEFINES_SVH
`define FRUSTUM_CULL_TEST_DEFINES_SVH

`define FCT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define FCT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/fct_pkg.sv =====
package fct_pkg;

    localparam int PLANE_COUNT_DEF   = 6;
    localparam int COORD_BITS_DEF    = 32;
    localparam int FRACTION_BITS_DEF = 16;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_BOX    = 2'd1;
    localparam logic [1:0] OP_SPHERE = 2'd2;

    typedef struct packed {
        logic [1:0]         op;
        logic [2:0]         plane_index;
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] vec_z;
        logic signed [31:0] scalar_w;
        logic [30:0]        size_x;
        logic [30:0]        size_y;
        logic [30:0]        size_z;
    } item_t;

    typedef struct packed {
        logic       visible;
        logic [2:0] rejecting_plane;
    } result_t;

endpackage

// ===== rtl/core/frustum_cull_test.sv =====
// Frustum culling test against a store of planes held in signed fixed point.
// A command beat is taken at a rising edge where start is high and busy is low.
// Op load writes one plane (normal and offset) and answers on the next cycle
// with visible low; busy stays low, so loads may follow each other every cycle.
// Op box or op sphere tests a volume against every stored plane in turn and
// reports whether it is visible and the lowest plane that rejected it.
// One shared multiplier forms one product per cycle, six per plane, and one
// accumulator sums them with the plane offset; the planes are tested in turn.
// Busy is high for the whole test; the result beat follows on the cycle after.
// Each result beat is shown on result for one cycle with done high and is
// taken at the edge that ends that cycle; the receiver cannot stall it.
// Reset clears all planes to zero and leaves the block idle with done low.
module frustum_cull_test
#(
    parameter int PLANE_COUNT   = fct_pkg::PLANE_COUNT_DEF,
    parameter int COORD_BITS    = fct_pkg::COORD_BITS_DEF,
    parameter int FRACTION_BITS = fct_pkg::FRACTION_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  fct_pkg::item_t   item,
    output logic             busy,
    output logic             done,
    output fct_pkg::result_t result
);
    import fct_pkg::*;
`include "frustum_cull_test_defines.svh"

    localparam int MUL_BITS  = (COORD_BITS + 1 > 32) ? COORD_BITS + 1 : 32;
    localparam int PROD_BITS = 2 * MUL_BITS;
    localparam int ACC_BITS  = PROD_BITS + 4;
    localparam int PIDX_BITS = $clog2(PLANE_COUNT + 1);
    localparam int SEL_BITS  = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    localparam logic [2:0] STEP_LAST_MUL = 3'd5;
    localparam logic [2:0] STEP_CHECK    = 3'd7;
    localparam logic [2:0] STEP_DOT_END  = 3'd3;

    localparam logic [PIDX_BITS-1:0] PLANE_NONE = PIDX_BITS'(PLANE_COUNT);
    localparam logic [PIDX_BITS-1:0] PLANE_LAST = PIDX_BITS'(PLANE_COUNT - 1);

    logic signed [COORD_BITS-1:0] normal_x_reg [PLANE_COUNT];
    logic signed [COORD_BITS-1:0] normal_y_reg [PLANE_COUNT];
    logic signed [COORD_BITS-1:0] normal_z_reg [PLANE_COUNT];
    logic signed [COORD_BITS-1:0] offset_reg   [PLANE_COUNT];

    logic                       state_reg, state_next;
    logic [PIDX_BITS-1:0]       plane_reg, plane_next;
    logic [2:0]                 step_reg, step_next;
    logic [PIDX_BITS-1:0]       reject_reg, reject_next;
    item_t                      item_reg;
    logic                       is_box_reg;
    logic                       prod_en_reg, prod_en_next;
    logic                       prod_dbl_reg, prod_dbl_next;
    logic signed [PROD_BITS-1:0] prod_reg;
    logic signed [ACC_BITS-1:0]  acc_reg, acc_next;
    logic                       done_reg, done_next;
    result_t                    result_reg, result_next;

    logic                       accept;
    logic                       load_hit;
    logic [SEL_BITS-1:0]        sel;
    logic signed [MUL_BITS-1:0] n_x, n_y, n_z;
    logic signed [MUL_BITS-1:0] mul_a, mul_b;
    logic signed [ACC_BITS-1:0] d_ext, prod_ext;

    assign accept   = start && !busy;
    assign load_hit = accept && (item.op == OP_LOAD)
                      && ({1'b0, item.plane_index} < 4'(PLANE_COUNT));
    assign sel      = plane_reg[SEL_BITS-1:0];

    assign n_x   = MUL_BITS'(normal_x_reg[sel]);
    assign n_y   = MUL_BITS'(normal_y_reg[sel]);
    assign n_z   = MUL_BITS'(normal_z_reg[sel]);
    assign d_ext = ACC_BITS'(offset_reg[sel]);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (step_reg)
            3'd0:
            begin
                mul_a = n_x;
                mul_b = MUL_BITS'($signed(item_reg.vec_x[COORD_BITS-1:0]));
            end
            3'd1:
            begin
                mul_a = n_y;
                mul_b = MUL_BITS'($signed(item_reg.vec_y[COORD_BITS-1:0]));
            end
            3'd2:
            begin
                mul_a = n_z;
                mul_b = MUL_BITS'($signed(item_reg.vec_z[COORD_BITS-1:0]));
            end
            3'd3:
            begin
                if (is_box_reg)
                begin
                    mul_a = n_x[MUL_BITS-1] ? -n_x : n_x;
                    mul_b = $signed(MUL_BITS'(item_reg.size_x));
                end
                else
                begin
                    mul_a = MUL_BITS'($signed(item_reg.scalar_w[COORD_BITS-1:0]));
                    mul_b = MUL_BITS'(1) <<< FRACTION_BITS;
                end
            end
            3'd4:
            begin
                if (is_box_reg)
                begin
                    mul_a = n_y[MUL_BITS-1] ? -n_y : n_y;
                    mul_b = $signed(MUL_BITS'(item_reg.size_y));
                end
            end
            3'd5:
            begin
                if (is_box_reg)
                begin
                    mul_a = n_z[MUL_BITS-1] ? -n_z : n_z;
                    mul_b = $signed(MUL_BITS'(item_reg.size_z));
                end
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_ext = prod_dbl_reg ? (ACC_BITS'(prod_reg) <<< 1) : ACC_BITS'(prod_reg);

    always_comb
    begin
        state_next    = state_reg;
        plane_next    = plane_reg;
        step_next     = step_reg;
        reject_next   = reject_reg;
        prod_en_next  = 1'b0;
        prod_dbl_next = 1'b0;
        acc_next      = acc_reg;
        done_next     = 1'b0;
        result_next   = result_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (item.op == OP_BOX || item.op == OP_SPHERE)
                    begin
                        state_next  = ST_RUN;
                        plane_next  = '0;
                        step_next   = '0;
                        reject_next = PLANE_NONE;
                    end
                    else
                    begin
                        done_next                   = 1'b1;
                        result_next.visible         = 1'b0;
                        result_next.rejecting_plane = 3'(PLANE_COUNT);
                    end
                end
            end
            ST_RUN:
            begin
                if (step_reg <= STEP_LAST_MUL)
                begin
                    prod_en_next  = 1'b1;
                    prod_dbl_next = is_box_reg && (step_reg < STEP_DOT_END);
                end
                if (step_reg == 3'd0)
                begin
                    acc_next = is_box_reg ? (d_ext <<< (FRACTION_BITS + 1))
                                          : (d_ext <<< FRACTION_BITS);
                end
                else if (prod_en_reg)
                begin
                    acc_next = acc_reg + prod_ext;
                end
                step_next = step_reg + 3'd1;
                if (step_reg == STEP_CHECK)
                begin
                    if (acc_reg[ACC_BITS-1] && reject_reg == PLANE_NONE)
                    begin
                        reject_next = plane_reg;
                    end
                    if (plane_reg == PLANE_LAST)
                    begin
                        state_next = ST_IDLE;
                        done_next  = 1'b1;
                        if (acc_reg[ACC_BITS-1] && reject_reg == PLANE_NONE)
                        begin
                            result_next.visible         = 1'b0;
                            result_next.rejecting_plane = 3'(plane_reg);
                        end
                        else
                        begin
                            result_next.visible         = (reject_reg == PLANE_NONE);
                            result_next.rejecting_plane = 3'(reject_reg);
                        end
                    end
                    else
                    begin
                        plane_next = plane_reg + PIDX_BITS'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            plane_reg    <= '0;
            step_reg     <= '0;
            reject_reg   <= '0;
            prod_en_reg  <= 1'b0;
            prod_dbl_reg <= 1'b0;
            done_reg     <= 1'b0;
            for (int i = 0; i < PLANE_COUNT; i++)
            begin
                normal_x_reg[i] <= '0;
                normal_y_reg[i] <= '0;
                normal_z_reg[i] <= '0;
                offset_reg[i]   <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            plane_reg    <= plane_next;
            step_reg     <= step_next;
            reject_reg   <= reject_next;
            prod_en_reg  <= prod_en_next;
            prod_dbl_reg <= prod_dbl_next;
            done_reg     <= done_next;
            if (load_hit)
            begin
                normal_x_reg[item.plane_index[SEL_BITS-1:0]] <= item.vec_x[COORD_BITS-1:0];
                normal_y_reg[item.plane_index[SEL_BITS-1:0]] <= item.vec_y[COORD_BITS-1:0];
                normal_z_reg[item.plane_index[SEL_BITS-1:0]] <= item.vec_z[COORD_BITS-1:0];
                offset_reg[item.plane_index[SEL_BITS-1:0]]   <= item.scalar_w[COORD_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg   <= item;
            is_box_reg <= (item.op == OP_BOX);
        end
        prod_reg   <= mul_a * mul_b;
        acc_reg    <= acc_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg == ST_RUN);
    assign done   = done_reg;
    assign result = result_reg;

    `FCT_ASSERT_NEXT(a_test_goes_busy, accept && (item.op == OP_BOX || item.op == OP_SPHERE), busy && !done, "A test beat did not start the plane sequence.")
    `FCT_ASSERT_NEXT(a_load_answers, accept && !(item.op == OP_BOX || item.op == OP_SPHERE), done && !result.visible, "A load beat did not answer on the next cycle.")
    `FCT_ASSERT_SAME(a_visible_code, done && result.visible, result.rejecting_plane == 3'(PLANE_COUNT), "A visible result names a rejecting plane.")
    `FCT_ASSERT_SAME(a_no_done_busy, busy, !done, "A result beat appeared while a test was running.")

endmodule

// ===== tb/testbench.sv =====
module testbench;
    import fct_pkg::*;

    localparam int                 PLANES      = PLANE_COUNT_DEF;
    localparam int                 UNIT        = 1 << FRACTION_BITS_DEF;
    localparam int                 TEST_CYCLES = 8 * PLANES + 1;
    localparam int                 CYCLE_LIMIT = 400000;
    localparam logic [1:0]         OP_SPARE    = 2'd3;
    localparam logic signed [71:0] SCALE       = 72'sd1 <<< FRACTION_BITS_DEF;
    localparam logic signed [31:0] MOST_NEG    = 32'sh8000_0000;
    localparam logic signed [31:0] MOST_POS    = 32'sh7fff_ffff;
    localparam logic [30:0]        SIZE_MAX    = 31'h7fff_ffff;

    logic    clk   = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    item_t   item  = '0;
    logic    busy;
    logic    done;
    result_t result;

    logic signed [31:0] plane_nx  [PLANES] = '{default: '0};
    logic signed [31:0] plane_ny  [PLANES] = '{default: '0};
    logic signed [31:0] plane_nz  [PLANES] = '{default: '0};
    logic signed [31:0] plane_off [PLANES] = '{default: '0};

    result_t cull_verdicts [$];
    int      fail_count  = 0;
    int      n_load      = 0;
    int      n_box       = 0;
    int      n_sphere    = 0;
    int      n_culled    = 0;
    int      gap_pct     = 0;
    int      cycle_count = 0;

    always #1 clk = ~clk;

    frustum_cull_test u_top
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    function automatic result_t predict_cull(item_t it);
        result_t            verdict;
        logic signed [71:0] nx, ny, nz, off, vx, vy, vz, w, sx, sy, sz, dot, acc;
        verdict.visible         = 1'b0;
        verdict.rejecting_plane = 3'(PLANES);
        if (it.op == OP_LOAD)
        begin
            if (it.plane_index < PLANES)
            begin
                plane_nx[it.plane_index]  = it.vec_x;
                plane_ny[it.plane_index]  = it.vec_y;
                plane_nz[it.plane_index]  = it.vec_z;
                plane_off[it.plane_index] = it.scalar_w;
            end
        end
        else if (it.op == OP_BOX || it.op == OP_SPHERE)
        begin
            vx = $signed(it.vec_x);
            vy = $signed(it.vec_y);
            vz = $signed(it.vec_z);
            w  = $signed(it.scalar_w);
            sx = {41'd0, it.size_x};
            sy = {41'd0, it.size_y};
            sz = {41'd0, it.size_z};
            for (int p = 0; p < PLANES; p++)
            begin
                nx  = plane_nx[p];
                ny  = plane_ny[p];
                nz  = plane_nz[p];
                off = plane_off[p];
                dot = nx * vx + ny * vy + nz * vz + off * SCALE;
                if (it.op == OP_BOX)
                    acc = 72'sd2 * dot + ((nx < 0) ? -nx : nx) * sx
                        + ((ny < 0) ? -ny : ny) * sy + ((nz < 0) ? -nz : nz) * sz;
                else
                    acc = dot + w * SCALE;
                if (acc < 0 && verdict.rejecting_plane == 3'(PLANES))
                    verdict.rejecting_plane = 3'(p);
            end
            verdict.visible = (verdict.rejecting_plane == 3'(PLANES));
        end
        return verdict;
    endfunction

    function automatic item_t make_item(logic [1:0] op, logic [2:0] idx,
                                        logic signed [31:0] x, logic signed [31:0] y,
                                        logic signed [31:0] z, logic signed [31:0] w,
                                        logic [30:0] sx, logic [30:0] sy, logic [30:0] sz);
        item_t it;
        it.op          = op;
        it.plane_index = idx;
        it.vec_x       = x;
        it.vec_y       = y;
        it.vec_z       = z;
        it.scalar_w    = w;
        it.size_x      = sx;
        it.size_y      = sy;
        it.size_z      = sz;
        return it;
    endfunction

    function automatic logic signed [31:0] scene_val(int span);
        return $signed($urandom_range(2 * span)) - span;
    endfunction

    function automatic item_t wild_item(logic [1:0] op);
        return make_item(op, 3'($urandom_range(7)), $urandom, $urandom, $urandom,
                         $urandom, 31'($urandom), 31'($urandom), 31'($urandom));
    endfunction

    function automatic item_t scene_plane(logic [2:0] idx);
        return make_item(OP_LOAD, idx, scene_val(UNIT), scene_val(UNIT), scene_val(UNIT),
                         scene_val(16 * UNIT), 31'($urandom), 31'($urandom),
                         31'($urandom));
    endfunction

    function automatic item_t scene_volume();
        logic signed [31:0] radius;
        radius = ($urandom_range(9) == 0) ? -$signed($urandom_range(UNIT))
                                          : $signed($urandom_range(8 * UNIT));
        if ($urandom_range(1) == 0)
            return make_item(OP_BOX, 3'($urandom_range(7)), scene_val(24 * UNIT),
                             scene_val(24 * UNIT), scene_val(24 * UNIT), $urandom,
                             31'($urandom_range(16 * UNIT)),
                             31'($urandom_range(16 * UNIT)),
                             31'($urandom_range(16 * UNIT)));
        return make_item(OP_SPHERE, 3'($urandom_range(7)), scene_val(24 * UNIT),
                         scene_val(24 * UNIT), scene_val(24 * UNIT), radius,
                         31'($urandom), 31'($urandom), 31'($urandom));
    endfunction

    task automatic idle_for(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic send_beat(item_t it);
        result_t verdict;
        if (gap_pct > 0 && $urandom_range(99) < gap_pct)
            idle_for($urandom_range(1, 13));
        start <= 1'b1;
        item  <= it;
        do
            @(posedge clk);
        while (busy);
        verdict = predict_cull(it);
        cull_verdicts.push_back(verdict);
        if (it.op == OP_BOX)
            n_box++;
        else if (it.op == OP_SPHERE)
            n_sphere++;
        else
            n_load++;
        if ((it.op == OP_BOX || it.op == OP_SPHERE) && !verdict.visible)
            n_culled++;
    endtask

    task automatic wait_results();
        start <= 1'b0;
        @(posedge clk);
        while (cull_verdicts.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done)
        begin
            if (cull_verdicts.size() == 0)
            begin
                $error("result beat with no verdict pending: visible=%0d rejecting_plane=%0d",
                       result.visible, result.rejecting_plane);
                fail_count++;
            end
            else
            begin
                want = cull_verdicts.pop_front();
                if (result.visible !== want.visible)
                begin
                    $error("visible: expected %0d, actual %0d", want.visible, result.visible);
                    fail_count++;
                end
                if (result.rejecting_plane !== want.rejecting_plane)
                begin
                    $error("rejecting_plane: expected %0d, actual %0d",
                           want.rejecting_plane, result.rejecting_plane);
                    fail_count++;
                end
            end
        end
    end

    // The store is all zero here, so only a negative sphere radius can be rejected.
    task automatic test_zero_planes();
        send_beat(make_item(OP_BOX, 3'd0, MOST_NEG, MOST_POS, MOST_NEG, MOST_POS,
                            SIZE_MAX, 31'd0, SIZE_MAX));
        send_beat(make_item(OP_SPHERE, 3'd7, MOST_POS, MOST_NEG, 32'sd0, 32'sd0,
                            31'd0, SIZE_MAX, 31'd0));
        send_beat(make_item(OP_SPHERE, 3'd0, 32'sd0, 32'sd0, 32'sd0, -32'sd1,
                            31'd0, 31'd0, 31'd0));
        send_beat(make_item(OP_SPHERE, 3'd4, 32'sd5, -32'sd5, 32'sd0, MOST_NEG,
                            31'd0, 31'd0, 31'd0));
    endtask

    task automatic test_load_answers();
        send_beat(make_item(OP_LOAD, 3'd0, 32'sd0, 32'sd0, 32'sd0, -32'sd1,
                            31'd0, 31'd0, 31'd0));
        send_beat(make_item(OP_LOAD, 3'd6, 32'sd0, 32'sd0, 32'sd0, MOST_NEG,
                            SIZE_MAX, SIZE_MAX, SIZE_MAX));
        send_beat(make_item(OP_LOAD, 3'd7, MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG,
                            31'd0, 31'd0, 31'd0));
        send_beat(make_item(OP_SPARE, 3'd1, MOST_POS, MOST_POS, MOST_POS, MOST_NEG,
                            SIZE_MAX, SIZE_MAX, SIZE_MAX));
        send_beat(make_item(OP_SPHERE, 3'd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0,
                            31'd0, 31'd0, 31'd0));
    endtask

    task automatic test_extreme_planes();
        send_beat(make_item(OP_LOAD, 3'd0, MOST_NEG, MOST_POS, 32'sd0, MOST_NEG,
                            31'd0, 31'd0, 31'd0));
        send_beat(make_item(OP_LOAD, 3'd1, MOST_POS, MOST_NEG, MOST_NEG, MOST_POS,
                            31'd0, 31'd0, 31'd0));
        send_beat(make_item(OP_LOAD, 3'd2, 32'sd0, 32'sd0, MOST_POS, 32'sd0,
                            31'd0, 31'd0, 31'd0));
        send_beat(make_item(OP_LOAD, 3'd3, UNIT, 32'sd0, 32'sd0, 32'sd0,
                            31'd0, 31'd0, 31'd0));
        send_beat(make_item(OP_LOAD, 3'd4, -32'sd1, 32'sd1, -32'sd1, -32'sd1,
                            31'd0, 31'd0, 31'd0));
        send_beat(make_item(OP_LOAD, 3'd5, MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG,
                            31'd0, 31'd0, 31'd0));
        send_beat(make_item(OP_BOX, 3'd0, MOST_NEG, MOST_NEG, MOST_NEG, 32'sd0,
                            SIZE_MAX, SIZE_MAX, SIZE_MAX));
        send_beat(make_item(OP_BOX, 3'd0, MOST_POS, MOST_POS, MOST_POS, 32'sd0,
                            31'd0, 31'd0, 31'd0));
        send_beat(make_item(OP_BOX, 3'd5, MOST_NEG, MOST_POS, MOST_NEG, MOST_NEG,
                            SIZE_MAX, 31'd0, SIZE_MAX));
        send_beat(make_item(OP_SPHERE, 3'd0, MOST_POS, MOST_NEG, MOST_POS, MOST_POS,
                            31'd0, 31'd0, 31'd0));
        send_beat(make_item(OP_SPHERE, 3'd0, MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG,
                            31'd0, 31'd0, 31'd0));
    endtask

    // A scene is six plane loads, mostly sensible, followed by volumes mostly placed around them.
    task automatic test_random_scenes();
        for (int round = 0; round < 34; round++)
        begin
            gap_pct = (round % 3 == 0) ? 0 : $urandom_range(15, 60);
            for (int p = 0; p < PLANES; p++)
                send_beat(($urandom_range(7) == 0) ? wild_item(OP_LOAD)
                                                    : scene_plane(3'(p)));
            for (int n = 0; n < 12; n++)
            begin
                case ($urandom_range(19))
                    0: send_beat(wild_item(OP_BOX));
                    1: send_beat(wild_item(OP_SPHERE));
                    2: send_beat(wild_item(3'($urandom_range(1)) ? OP_SPARE : OP_LOAD));
                    default: send_beat(scene_volume());
                endcase
            end
            if (round % 8 == 5)
                wait_results();
        end
    endtask

    task automatic test_wild_items();
        gap_pct = 30;
        for (int n = 0; n < 60; n++)
            send_beat(wild_item(2'($urandom_range(3))));
    endtask

    task automatic test_back_to_back();
        gap_pct = 0;
        for (int p = 0; p < PLANES; p++)
            send_beat(scene_plane(3'(p)));
        for (int n = 0; n < 60; n++)
            send_beat(($urandom_range(5) == 0) ? scene_plane(3'($urandom_range(7)))
                                                : scene_volume());
    endtask

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_zero_planes();
        test_load_answers();
        test_extreme_planes();
        test_random_scenes();
        test_wild_items();
        test_back_to_back();
        wait_results();
        repeat (TEST_CYCLES + 10) @(posedge clk);
        $display("Sent %0d load or spare beats, %0d box tests and %0d sphere tests.",
                 n_load, n_box, n_sphere);
        $display("%0d tested volumes were culled; %0d mismatches seen.", n_culled, fail_count);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
